[rtl/atp_pkg.sv]
// ----------------------------------------------------------------------------
// atp_pkg
// Shared widths, register codes, sideband type and arctangent table for the
// tilt angle pipeline.
// ----------------------------------------------------------------------------
package atp_pkg;

  localparam int IN_W      = 16;
  localparam int OUT_W     = 17;
  localparam int SQ_W      = 2 * IN_W;
  localparam int ROOT_W    = 24;
  localparam int REM_W     = ROOT_W + 3;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int MAG_W     = 24;
  localparam int CW        = 27;
  localparam int ACC_W     = 24;
  localparam int TABLE_LEN = 24;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RELATIVE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_ROLL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_PITCH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_REF_YAW   = 3'd3;

  localparam logic signed [ACC_W-1:0] RIGHT_FINE  = 24'sd5898240;
  localparam logic signed [OUT_W-1:0] RIGHT_ANGLE = 17'sd23040;
  localparam logic signed [OUT_W:0]   HALF_TURN   = 18'sd46080;
  localparam logic signed [OUT_W:0]   FULL_TURN   = 18'sd92160;

  typedef struct packed {
    logic [IN_W-1:0] mag_x;
    logic [IN_W-1:0] mag_y;
    logic [IN_W-1:0] mag_z;
    logic            neg_x;
    logic            neg_y;
    logic            neg_z;
    logic            zero_x;
    logic            zero_y;
    logic            zero_z;
  } atp_side_t;

  // atan(2^-i) in 1/65536 degree
  function automatic logic signed [ACC_W-1:0] atan_fine(input int i);
    logic signed [ACC_W-1:0] v;
    case (i)
      0:  v = 24'sd2949120;
      1:  v = 24'sd1740967;
      2:  v = 24'sd919879;
      3:  v = 24'sd466945;
      4:  v = 24'sd234379;
      5:  v = 24'sd117304;
      6:  v = 24'sd58666;
      7:  v = 24'sd29335;
      8:  v = 24'sd14668;
      9:  v = 24'sd7334;
      10: v = 24'sd3667;
      11: v = 24'sd1833;
      12: v = 24'sd917;
      13: v = 24'sd458;
      14: v = 24'sd229;
      15: v = 24'sd115;
      16: v = 24'sd57;
      17: v = 24'sd29;
      18: v = 24'sd14;
      19: v = 24'sd7;
      20: v = 24'sd4;
      21: v = 24'sd2;
      22: v = 24'sd1;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/atp_sqrt.sv]
// ----------------------------------------------------------------------------
// atp_sqrt
// Pipelined root of a sum of two squares with 8 fraction bits, one root bit
// per stage after a summing stage.
// ----------------------------------------------------------------------------
module atp_sqrt (
  input  logic                       clk,
  input  logic [atp_pkg::ROOT_W:0]   en,
  input  logic [atp_pkg::SQ_W-1:0]   sq_a,
  input  logic [atp_pkg::SQ_W-1:0]   sq_b,
  output logic [atp_pkg::ROOT_W-1:0] root
);
  import atp_pkg::*;

  logic [SQ_W-1:0]   sum_r;
  logic [REM_W-1:0]  rem_q  [0:ROOT_W-1];
  logic [ROOT_W-1:0] root_q [0:ROOT_W-1];
  logic [RAD_W-1:0]  rad_q  [0:ROOT_W-1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sum_r <= sq_a + sq_b;
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_digit
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = {sum_r, {(RAD_W-SQ_W){1'b0}}};
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1:RAD_W-2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en[k+1]) begin
        rem_q[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_q[k] <= {root_in[ROOT_W-2:0], ge};
        rad_q[k]  <= {rad_in[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_q[ROOT_W-1];

endmodule

[rtl/atp_cordic.sv]
// ----------------------------------------------------------------------------
// atp_cordic
// One vectoring CORDIC lane, one rotation per pipeline stage; the angle
// accumulator counts 1/65536 degree.
// ----------------------------------------------------------------------------
module atp_cordic #(
  parameter int STAGES = atp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic [STAGES-1:0]                en,
  input  logic [atp_pkg::MAG_W-1:0]        num_mag,
  input  logic [atp_pkg::MAG_W-1:0]        den_mag,
  output logic signed [atp_pkg::ACC_W-1:0] acc
);
  import atp_pkg::*;

  logic signed [CW-1:0]    x_q   [0:STAGES-1];
  logic signed [CW-1:0]    y_q   [0:STAGES-1];
  logic signed [ACC_W-1:0] acc_q [0:STAGES-1];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [CW-1:0]    x_in;
    logic signed [CW-1:0]    y_in;
    logic signed [ACC_W-1:0] acc_in;
    logic signed [CW-1:0]    dx;
    logic signed [CW-1:0]    dy;

    if (i == 0) begin : g_first
      assign x_in   = $signed({{(CW-MAG_W){1'b0}}, den_mag});
      assign y_in   = $signed({{(CW-MAG_W){1'b0}}, num_mag});
      assign acc_in = '0;
    end else begin : g_next
      assign x_in   = x_q[i-1];
      assign y_in   = y_q[i-1];
      assign acc_in = acc_q[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk) begin
      if (en[i]) begin
        if (!y_in[CW-1]) begin
          x_q[i]   <= x_in + dx;
          y_q[i]   <= y_in - dy;
          acc_q[i] <= acc_in + atan_fine(i);
        end else begin
          x_q[i]   <= x_in - dx;
          y_q[i]   <= y_in + dy;
          acc_q[i] <= acc_in - atan_fine(i);
        end
      end
    end
  end

  assign acc = acc_q[STAGES-1];

endmodule

[rtl/atp_merge.sv]
// ----------------------------------------------------------------------------
// atp_merge
// Combines the three lane accumulators: clamp, round, sign, special cases,
// reference subtraction and wrap.
// ----------------------------------------------------------------------------
module atp_merge (
  input  logic signed [atp_pkg::ACC_W-1:0]     acc_roll,
  input  logic signed [atp_pkg::ACC_W-1:0]     acc_pitch,
  input  logic signed [atp_pkg::ACC_W-1:0]     acc_yaw,
  input  atp_pkg::atp_side_t                   side,
  input  logic                                 relative_enable,
  input  logic signed [atp_pkg::CFG_DAT_W-1:0] ref_roll,
  input  logic signed [atp_pkg::CFG_DAT_W-1:0] ref_pitch,
  input  logic signed [atp_pkg::CFG_DAT_W-1:0] ref_yaw,
  output logic signed [atp_pkg::OUT_W-1:0]     roll_angle,
  output logic signed [atp_pkg::OUT_W-1:0]     pitch_angle,
  output logic signed [atp_pkg::OUT_W-1:0]     yaw_angle,
  output logic                                 degenerate
);
  import atp_pkg::*;

  function automatic logic signed [OUT_W-1:0] finish(
    input logic signed [ACC_W-1:0]     a,
    input logic                        num_zero,
    input logic                        den_zero,
    input logic                        neg,
    input logic                        rel,
    input logic signed [CFG_DAT_W-1:0] refv
  );
    logic signed [ACC_W-1:0] c;
    logic signed [ACC_W-1:0] r;
    logic signed [OUT_W-1:0] m;
    logic signed [OUT_W-1:0] v;
    logic signed [OUT_W:0]   d;
    c = a;
    if (a < 0) begin
      c = '0;
    end else if (a > RIGHT_FINE) begin
      c = RIGHT_FINE;
    end
    r = (c + 24'sd128) >>> 8;
    m = r[OUT_W-1:0];
    if (num_zero) begin
      v = '0;
    end else if (den_zero) begin
      v = neg ? -RIGHT_ANGLE : RIGHT_ANGLE;
    end else begin
      v = neg ? -m : m;
    end
    if (rel) begin
      d = {v[OUT_W-1], v} - {{(OUT_W+1-CFG_DAT_W){refv[CFG_DAT_W-1]}}, refv};
      if (d > HALF_TURN) begin
        d = d - FULL_TURN;
      end
      if (d < -HALF_TURN) begin
        d = d + FULL_TURN;
      end
      v = d[OUT_W-1:0];
    end
    return v;
  endfunction

  logic degen;

  assign degen = side.zero_x & side.zero_y & side.zero_z;

  always_comb begin
    degenerate = degen;
    if (degen) begin
      roll_angle  = '0;
      pitch_angle = '0;
      yaw_angle   = '0;
    end else begin
      roll_angle  = finish(acc_roll, side.zero_x, side.zero_y & side.zero_z,
                           side.neg_x, relative_enable, ref_roll);
      pitch_angle = finish(acc_pitch, side.zero_y, side.zero_x & side.zero_z,
                           side.neg_y, relative_enable, ref_pitch);
      yaw_angle   = finish(acc_yaw, side.zero_x & side.zero_y, side.zero_z,
                           side.neg_z, relative_enable, ref_yaw);
    end
  end

endmodule

[rtl/accel_tilt_angles_top.sv]
// ----------------------------------------------------------------------------
// accel_tilt_angles_top
// Tilt angles (roll, pitch, yaw) from one three-axis accelerometer sample,
// using three root lanes and three CORDIC lanes side by side.
// ----------------------------------------------------------------------------
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    accel_x, accel_y, accel_z
//   out      out  out_valid / out_ready  roll/pitch/yaw_angle, degenerate
//   cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per cycle while out_ready is high; the pipeline runs through the
// square stage, the summing stage, 24 root digit stages, the CORDIC stages
// and the output register. Each stage holds its word only while the next is
// full, so a stalled output fills bubbles before input stops. Reset clears
// the stage valids and config registers; cfg_ready is always high.
// ----------------------------------------------------------------------------
module accel_tilt_angles_top #(
  parameter int CORDIC_STAGES = atp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [atp_pkg::IN_W-1:0]      accel_x,
  input  logic signed [atp_pkg::IN_W-1:0]      accel_y,
  input  logic signed [atp_pkg::IN_W-1:0]      accel_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [atp_pkg::OUT_W-1:0]     roll_angle,
  output logic signed [atp_pkg::OUT_W-1:0]     pitch_angle,
  output logic signed [atp_pkg::OUT_W-1:0]     yaw_angle,
  output logic                                 degenerate,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [atp_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [atp_pkg::CFG_DAT_W-1:0]        cfg_data
);
  import atp_pkg::*;

  localparam int CS     = CORDIC_STAGES;
  localparam int SQ0    = 1;
  localparam int CO0    = SQ0 + ROOT_W + 1;
  localparam int NSTAGE = CO0 + CS + 1;

  logic [NSTAGE-1:0] valid;
  logic [NSTAGE:0]   rdy;
  logic [NSTAGE-1:0] vin;
  logic [NSTAGE-1:0] load;

  logic                        relative_enable;
  logic signed [CFG_DAT_W-1:0] ref_roll;
  logic signed [CFG_DAT_W-1:0] ref_pitch;
  logic signed [CFG_DAT_W-1:0] ref_yaw;

  atp_side_t side [0:NSTAGE-2];
  atp_side_t side_in;

  logic [SQ_W-1:0] sq_x;
  logic [SQ_W-1:0] sq_y;
  logic [SQ_W-1:0] sq_z;

  logic [ROOT_W-1:0] root_yz;
  logic [ROOT_W-1:0] root_xz;
  logic [ROOT_W-1:0] root_xy;

  logic signed [ACC_W-1:0] acc_roll;
  logic signed [ACC_W-1:0] acc_pitch;
  logic signed [ACC_W-1:0] acc_yaw;

  logic signed [OUT_W-1:0] roll_next;
  logic signed [OUT_W-1:0] pitch_next;
  logic signed [OUT_W-1:0] yaw_next;
  logic                    degen_next;

  // stage handshake chain
  always_comb begin
    rdy[NSTAGE] = out_ready;
    for (int k = NSTAGE - 1; k >= 0; k--) begin
      rdy[k] = !valid[k] || rdy[k+1];
    end
    vin[0] = in_valid;
    for (int k = 1; k < NSTAGE; k++) begin
      vin[k] = valid[k-1];
    end
    load = vin & rdy[NSTAGE-1:0];
  end

  assign in_ready  = rdy[0];
  assign out_valid = valid[NSTAGE-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (rdy[k]) begin
          valid[k] <= vin[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relative_enable <= 1'b0;
      ref_roll        <= '0;
      ref_pitch       <= '0;
      ref_yaw         <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RELATIVE:  relative_enable <= cfg_data[0];
        CFG_REF_ROLL:  ref_roll        <= cfg_data;
        CFG_REF_PITCH: ref_pitch       <= cfg_data;
        CFG_REF_YAW:   ref_yaw         <= cfg_data;
        default: ;
      endcase
    end
  end

  // magnitudes and flags of the input word
  always_comb begin
    logic [IN_W:0] nx;
    logic [IN_W:0] ny;
    logic [IN_W:0] nz;
    nx = -{accel_x[IN_W-1], accel_x};
    ny = -{accel_y[IN_W-1], accel_y};
    nz = -{accel_z[IN_W-1], accel_z};
    side_in.neg_x  = accel_x[IN_W-1];
    side_in.neg_y  = accel_y[IN_W-1];
    side_in.neg_z  = accel_z[IN_W-1];
    side_in.mag_x  = accel_x[IN_W-1] ? nx[IN_W-1:0] : accel_x;
    side_in.mag_y  = accel_y[IN_W-1] ? ny[IN_W-1:0] : accel_y;
    side_in.mag_z  = accel_z[IN_W-1] ? nz[IN_W-1:0] : accel_z;
    side_in.zero_x = (accel_x == '0);
    side_in.zero_y = (accel_y == '0);
    side_in.zero_z = (accel_z == '0);
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      side[0] <= side_in;
      sq_x    <= side_in.mag_x * side_in.mag_x;
      sq_y    <= side_in.mag_y * side_in.mag_y;
      sq_z    <= side_in.mag_z * side_in.mag_z;
    end
  end

  for (genvar k = 1; k < NSTAGE - 1; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (load[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  atp_sqrt u_sqrt_yz (
    .clk  (clk),
    .en   (load[CO0-1:SQ0]),
    .sq_a (sq_y),
    .sq_b (sq_z),
    .root (root_yz)
  );

  atp_sqrt u_sqrt_xz (
    .clk  (clk),
    .en   (load[CO0-1:SQ0]),
    .sq_a (sq_x),
    .sq_b (sq_z),
    .root (root_xz)
  );

  atp_sqrt u_sqrt_xy (
    .clk  (clk),
    .en   (load[CO0-1:SQ0]),
    .sq_a (sq_x),
    .sq_b (sq_y),
    .root (root_xy)
  );

  atp_cordic #(.STAGES(CS)) u_cordic_roll (
    .clk     (clk),
    .en      (load[CO0+CS-1:CO0]),
    .num_mag ({side[CO0-1].mag_x, 8'h00}),
    .den_mag (root_yz),
    .acc     (acc_roll)
  );

  atp_cordic #(.STAGES(CS)) u_cordic_pitch (
    .clk     (clk),
    .en      (load[CO0+CS-1:CO0]),
    .num_mag ({side[CO0-1].mag_y, 8'h00}),
    .den_mag (root_xz),
    .acc     (acc_pitch)
  );

  atp_cordic #(.STAGES(CS)) u_cordic_yaw (
    .clk     (clk),
    .en      (load[CO0+CS-1:CO0]),
    .num_mag (root_xy),
    .den_mag ({side[CO0-1].mag_z, 8'h00}),
    .acc     (acc_yaw)
  );

  atp_merge u_merge (
    .acc_roll        (acc_roll),
    .acc_pitch       (acc_pitch),
    .acc_yaw         (acc_yaw),
    .side            (side[NSTAGE-2]),
    .relative_enable (relative_enable),
    .ref_roll        (ref_roll),
    .ref_pitch       (ref_pitch),
    .ref_yaw         (ref_yaw),
    .roll_angle      (roll_next),
    .pitch_angle     (pitch_next),
    .yaw_angle       (yaw_next),
    .degenerate      (degen_next)
  );

  always_ff @(posedge clk) begin
    if (load[NSTAGE-1]) begin
      roll_angle  <= roll_next;
      pitch_angle <= pitch_next;
      yaw_angle   <= yaw_next;
      degenerate  <= degen_next;
    end
  end

endmodule

[sim/tb_accel_tilt_angles_top.sv]
// ----------------------------------------------------------------------------
// tb_accel_tilt_angles_top
// Self-checking testbench for the tilt angle pipeline. A queue-fed driver
// offers accelerometer samples with random gaps, a monitor compares every
// output word with a CORDIC-based angle predictor, and register settings
// are changed between phases while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_accel_tilt_angles_top;
  import atp_pkg::*;

  localparam int LATENCY = 27 + CORDIC_STAGES_DEF;
  localparam int WDOG_LIMIT = 3000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd6;

  typedef struct {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
  } sample_t;

  typedef struct {
    logic signed [OUT_W-1:0] roll;
    logic signed [OUT_W-1:0] pitch;
    logic signed [OUT_W-1:0] yaw;
    logic                    degen;
  } angles_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic signed [IN_W-1:0] accel_x = 0, accel_y = 0, accel_z = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [OUT_W-1:0] roll_angle, pitch_angle, yaw_angle;
  logic degenerate;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_DAT_W-1:0] cfg_data = 0;

  sample_t sample_q[$];
  angles_t angles_q[$];

  logic rel_mode = 0;
  logic signed [IN_W-1:0] base_roll = 0, base_pitch = 0, base_yaw = 0;

  int tx_idle_pct = 32;
  int rx_idle_pct = 59;
  int rx_hold = 0;
  int mismatches = 0;
  int words_out = 0;
  int idle_cycles = 0;
  bit in_took = 0;

  accel_tilt_angles_top u_top (.*);

  always #5 clk = ~clk;

  function automatic longint root_of(longint n);
    longint res, b;
    res = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - res - b;
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic longint hyp(longint p, longint q);
    return root_of((p * p + q * q) <<< 16);
  endfunction

  function automatic longint angle_of(longint num, longint den);
    longint cx, cy, acc, dx, dy, mag;
    bit neg;
    if (num == 0) return 0;
    if (den == 0) return num > 0 ? 23040 : -23040;
    neg = (num < 0) != (den < 0);
    cx = den < 0 ? -den : den;
    cy = num < 0 ? -num : num;
    acc = 0;
    for (int i = 0; i < CORDIC_STAGES_DEF && i < TABLE_LEN; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; acc += longint'(atan_fine(i));
      end else begin
        cx -= dx; cy += dy; acc -= longint'(atan_fine(i));
      end
    end
    if (acc < 0) acc = 0;
    if (acc > longint'(RIGHT_FINE)) acc = longint'(RIGHT_FINE);
    mag = (acc + 128) >>> 8;
    return neg ? -mag : mag;
  endfunction

  function automatic longint rewrap(longint a, longint b);
    longint d;
    d = a - b;
    if (d > 46080) d -= 92160;
    if (d < -46080) d += 92160;
    return d;
  endfunction

  function automatic angles_t predict_angles(sample_t s);
    angles_t r;
    longint x, y, z, ro, pi, ya;
    x = s.x; y = s.y; z = s.z;
    ro = 0; pi = 0; ya = 0;
    r.degen = (x == 0 && y == 0 && z == 0);
    if (!r.degen) begin
      ro = angle_of(x * 256, hyp(y, z));
      pi = angle_of(y * 256, hyp(x, z));
      ya = angle_of(hyp(x, y), z * 256);
      if (rel_mode) begin
        ro = rewrap(ro, base_roll);
        pi = rewrap(pi, base_pitch);
        ya = rewrap(ya, base_yaw);
      end
    end
    r.roll = ro[OUT_W-1:0];
    r.pitch = pi[OUT_W-1:0];
    r.yaw = ya[OUT_W-1:0];
    return r;
  endfunction

  // sample side: predictions, register shadow, result check, watchdog
  always @(posedge clk) begin
    angles_t e;
    in_took = !rst && in_valid && in_ready;
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RELATIVE:  rel_mode = cfg_data[0];
        CFG_REF_ROLL:  base_roll = cfg_data;
        CFG_REF_PITCH: base_pitch = cfg_data;
        CFG_REF_YAW:   base_yaw = cfg_data;
        default: ;
      endcase
    end
    if (in_took) angles_q.push_back(predict_angles('{accel_x, accel_y, accel_z}));
    if (!rst && out_valid && out_ready) begin
      words_out++;
      if (angles_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word");
      end else begin
        e = angles_q.pop_front();
        if (e.roll !== roll_angle || e.pitch !== pitch_angle ||
            e.yaw !== yaw_angle || e.degen !== degenerate) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d %0b got %0d %0d %0d %0b",
                     e.roll, e.pitch, e.yaw, e.degen,
                     roll_angle, pitch_angle, yaw_angle, degenerate);
        end
      end
    end
    if (in_took || (out_valid && out_ready) || (cfg_valid && cfg_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", WDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // driver
  always @(negedge clk) begin
    sample_t s;
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_took) begin
      if (sample_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        s = sample_q.pop_front();
        accel_x <= s.x;
        accel_y <= s.y;
        accel_z <= s.z;
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold = rx_hold - 1;
      out_ready <= 0;
    end else begin
      out_ready <= !rst && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic push_sample(int x, int y, int z);
    sample_t s;
    s.x = x; s.y = y; s.z = z;
    sample_q.push_back(s);
  endtask

  task automatic push_random(int n);
    int k, a, b, c;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(9);
      a = $signed(16'($urandom));
      b = $signed(16'($urandom));
      c = $signed(16'($urandom));
      if (k >= 6 && k <= 7) begin
        a = $urandom_range(511) - 256;
        b = $urandom_range(511) - 256;
        c = $urandom_range(511) - 256;
      end
      if (k >= 8) begin
        case ($urandom_range(2))
          0: a = 0;
          1: b = 0;
          default: c = 0;
        endcase
      end
      if (k == 9) begin
        if ($urandom_range(1)) b = 0; else c = 0;
      end
      push_sample(a, b, c);
    end
  endtask

  task automatic drain();
    wait (sample_q.size() == 0 && !in_valid && angles_q.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // absolute angles at reset settings
    push_sample(0, 0, 0);
    push_sample(32767, 0, 0);
    push_sample(-32768, 0, 0);
    push_sample(0, 32767, 0);
    push_sample(0, -32768, 0);
    push_sample(0, 0, 32767);
    push_sample(0, 0, -32768);
    push_sample(-32768, -32768, -32768);
    push_sample(32767, 32767, 32767);
    push_sample(32767, -32768, 32767);
    push_sample(-32768, 32767, -32768);
    push_sample(1, 0, 0);
    push_sample(0, -1, 0);
    push_sample(0, 0, -1);
    push_sample(100, -100, 0);
    push_sample(-5, 7, 0);
    push_sample(1, 1, 1);
    push_sample(-1, -1, -1);
    push_sample(0, 0, 0);
    push_random(230);
    drain();

    // relative mode with extreme and out-of-range references
    tx_idle_pct = 59;
    rx_idle_pct = 32;
    write_reg(CFG_RELATIVE, 16'h0001);
    write_reg(CFG_REF_ROLL, 16'(23040));
    write_reg(CFG_REF_PITCH, 16'(-23040));
    write_reg(CFG_REF_YAW, 16'h7fff);
    write_reg(CFG_UNUSED, 16'hffff);
    push_sample(0, 0, 0);
    push_sample(-32768, 32767, 0);
    push_sample(32767, -32768, -1);
    push_random(100);
    rx_hold = 400;
    tx_idle_pct = 0;
    wait (rx_hold == 0);
    tx_idle_pct = 59;
    push_random(150);
    drain();

    // other references, back-to-back traffic, a full sender pause
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(CFG_REF_ROLL, 16'h8000);
    write_reg(CFG_REF_PITCH, 16'h0000);
    write_reg(CFG_REF_YAW, 16'(-23040));
    push_random(120);
    wait (sample_q.size() == 0 && !in_valid && angles_q.size() == 0);
    push_random(130);
    drain();

    // back to absolute; upper data bits must be ignored
    tx_idle_pct = 32;
    rx_idle_pct = 59;
    write_reg(CFG_RELATIVE, 16'hfffe);
    push_random(200);
    drain();

    $display("Checked %0d angle words over absolute and relative modes,", words_out);
    $display("extreme references, long output stall and unthrottled traffic.");
    if (mismatches == 0 && angles_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatches, angles_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
